### rtl/core/rlt_pkg.sv
// Shared types and constants for the reply latency table unit.
`timescale 1ns / 1ps

package rlt_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int TIME_BITS_DEF   = 32;

	localparam int ADDR_W  = 32;
	localparam int DELAY_W = 32;
	localparam int SKIP_W  = 2;
	localparam int ERR_W   = 13;
	localparam int COUNT_W = 9;
	localparam int OTIME_W = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [COUNT_W-1:0] ENTRY_COUNT_RST = 9'd256;

	typedef enum logic [1:0] {
		KIND_LOG   = 2'd0,
		KIND_READ  = 2'd1,
		KIND_SKIP  = 2'd2,
		KIND_STATS = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE  = 1'd0,
		REG_COUNT = 1'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_WALK,
		ST_DIV,
		ST_FIN
	} state_t;

endpackage

### rtl/core/reply_latency_table_unit.sv
// Reply latency table: per-address latency store with log, read, skip and stats items.
`timescale 1ns / 1ps

// channel   direction  ports
// cfg       write      cfg_valid cfg_ready cfg_index cfg_data
// req       in         req_valid req_ready kind address measured_delay skip_code error_number
// rsp       out        rsp_valid rsp_ready in_range entry_* valid_count skipped_count *_time
//
// Log, read and skip beats do one memory read, then write-back and result load.
// Stats beats do one table read per cycle over the live entries, drain the last read, then
// run a one-bit-per-cycle divider for the mean (skipped if no valid entries). After reset
// a clearing pass writes every entry with req_ready low.
// A stalled rsp holds the unit in its final step; cfg is always ready.

module reply_latency_table_unit #(
	parameter int TABLE_DEPTH = rlt_pkg::TABLE_DEPTH_DEF,
	parameter int TIME_BITS   = rlt_pkg::TIME_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rlt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rlt_pkg::ADDR_W-1:0]         cfg_data,

	input  logic                               req_valid,
	output logic                               req_ready,
	input  logic [1:0]                         kind,
	input  logic [rlt_pkg::ADDR_W-1:0]         address,
	input  logic [rlt_pkg::DELAY_W-1:0]        measured_delay,
	input  logic [rlt_pkg::SKIP_W-1:0]         skip_code,
	input  logic signed [rlt_pkg::ERR_W-1:0]   error_number,

	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output logic                               in_range,
	output logic                               entry_valid,
	output logic [rlt_pkg::OTIME_W-1:0]        entry_time,
	output logic [rlt_pkg::SKIP_W-1:0]         entry_skip,
	output logic signed [rlt_pkg::ERR_W-1:0]   entry_error,
	output logic [rlt_pkg::COUNT_W-1:0]        valid_count,
	output logic [rlt_pkg::COUNT_W-1:0]        skipped_count,
	output logic [rlt_pkg::OTIME_W-1:0]        min_time,
	output logic [rlt_pkg::OTIME_W-1:0]        max_time,
	output logic [rlt_pkg::OTIME_W-1:0]        mean_time
);

	localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
	localparam int SUM_W   = (TIME_BITS + CNT_W > 64) ? 64 : TIME_BITS + CNT_W;
	localparam int DCNT_W  = $clog2(SUM_W + 1);
	localparam int SKIP_W  = rlt_pkg::SKIP_W;
	localparam int ERR_W   = rlt_pkg::ERR_W;
	localparam int ENTRY_W = 1 + TIME_BITS + SKIP_W + ERR_W;
	localparam int T_LO    = SKIP_W + ERR_W;

	localparam logic [TIME_BITS-1:0] NO_RESP = {TIME_BITS{1'b1}};

	// entry layout: {valid, time, skip, error}
	logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
	logic [ENTRY_W-1:0] rdata_q;

	rlt_pkg::state_t state_q, state_d;

	logic [rlt_pkg::ADDR_W-1:0]  base_q;
	logic [rlt_pkg::COUNT_W-1:0] count_q;
	logic [31:0]                 live;

	logic [rlt_pkg::ADDR_W-1:0] offset;
	logic                       hit_in;

	rlt_pkg::kind_t             kind_q;
	logic                       hit_q;
	logic [IDX_W-1:0]           slot_q;
	logic [rlt_pkg::DELAY_W-1:0] delay_q;
	logic [SKIP_W-1:0]          skip_q;
	logic [ERR_W-1:0]           err_q;

	logic [IDX_W-1:0]  clr_q;
	logic [CNT_W-1:0]  walk_q;
	logic              pend_s1;
	logic [CNT_W-1:0]  nvalid_q;
	logic [CNT_W-1:0]  nskip_q;
	logic [TIME_BITS-1:0] lo_q;
	logic [TIME_BITS-1:0] hi_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [DCNT_W-1:0] dcnt_q;

	logic              rsp_valid_q;
	logic              out_free;
	logic              req_acc;
	logic              issue;
	logic              walk_done;
	logic              div_last;
	logic              mem_we;
	logic              mem_re;
	logic              rsp_load;
	logic [IDX_W-1:0]  wr_addr;
	logic [IDX_W-1:0]  rd_addr;
	logic [ENTRY_W-1:0] wr_data;

	logic                 rd_v;
	logic [TIME_BITS-1:0] rd_t;
	logic [SKIP_W-1:0]    rd_skip;
	logic [ERR_W-1:0]     rd_err;
	logic [TIME_BITS-1:0] sat_delay;
	logic [CNT_W:0]       trial;
	logic                 trial_ge;

	assign cfg_ready = 1'b1;

	assign live = (32'(count_q) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : 32'(count_q);
	assign offset = address - base_q;
	assign hit_in = (address >= base_q) && (offset < live);

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_acc   = req_valid && req_ready;
	assign issue     = (state_q == rlt_pkg::ST_WALK) && (32'(walk_q) < live);
	assign walk_done = !issue && !pend_s1;
	assign div_last  = (dcnt_q == DCNT_W'(SUM_W - 1));

	assign rd_v    = rdata_q[ENTRY_W-1];
	assign rd_t    = rdata_q[T_LO +: TIME_BITS];
	assign rd_skip = rdata_q[ERR_W +: SKIP_W];
	assign rd_err  = rdata_q[ERR_W-1:0];

	assign sat_delay = (64'(delay_q) >= 64'(NO_RESP)) ? NO_RESP : TIME_BITS'(delay_q);

	assign trial    = {rem_q, quo_q[SUM_W-1]};
	assign trial_ge = trial >= {1'b0, nvalid_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rlt_pkg::ST_CLEAR: begin
				if (clr_q == IDX_W'(TABLE_DEPTH - 1)) state_d = rlt_pkg::ST_IDLE;
			end
			rlt_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = (rlt_pkg::kind_t'(kind) == rlt_pkg::KIND_STATS) ?
						rlt_pkg::ST_WALK : rlt_pkg::ST_EXEC;
				end
			end
			rlt_pkg::ST_EXEC: begin
				if (out_free) state_d = rlt_pkg::ST_IDLE;
			end
			rlt_pkg::ST_WALK: begin
				if (walk_done) begin
					state_d = (nvalid_q != '0) ? rlt_pkg::ST_DIV : rlt_pkg::ST_FIN;
				end
			end
			rlt_pkg::ST_DIV: begin
				if (div_last) state_d = rlt_pkg::ST_FIN;
			end
			rlt_pkg::ST_FIN: begin
				if (out_free) state_d = rlt_pkg::ST_IDLE;
			end
			default: state_d = rlt_pkg::ST_CLEAR;
		endcase
	end

	// control outputs
	always_comb begin
		req_ready = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		rsp_load  = 1'b0;
		wr_addr   = slot_q;
		rd_addr   = walk_q[IDX_W-1:0];
		wr_data   = {1'b0, NO_RESP, {SKIP_W{1'b0}}, {ERR_W{1'b0}}};
		case (state_q)
			rlt_pkg::ST_CLEAR: begin
				mem_we  = 1'b1;
				wr_addr = clr_q;
			end
			rlt_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				mem_re    = req_valid;
				rd_addr   = offset[IDX_W-1:0];
			end
			rlt_pkg::ST_EXEC: begin
				rsp_load = out_free;
				if (kind_q == rlt_pkg::KIND_LOG) begin
					mem_we  = out_free && hit_q;
					wr_data = {1'b1, sat_delay, rd_skip, rd_err};
				end else if (kind_q == rlt_pkg::KIND_SKIP) begin
					mem_we  = out_free && hit_q;
					wr_data = {1'b0, NO_RESP, skip_q, err_q};
				end
			end
			rlt_pkg::ST_WALK: begin
				mem_re = issue;
			end
			rlt_pkg::ST_DIV: begin
			end
			rlt_pkg::ST_FIN: begin
				rsp_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= wr_data;
		if (mem_re) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rlt_pkg::ST_CLEAR;
			base_q      <= '0;
			count_q     <= rlt_pkg::ENTRY_COUNT_RST;
			clr_q       <= '0;
			walk_q      <= '0;
			pend_s1     <= 1'b0;
			dcnt_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (rlt_pkg::reg_idx_t'(cfg_index))
					rlt_pkg::REG_BASE:  base_q  <= cfg_data;
					rlt_pkg::REG_COUNT: count_q <= cfg_data[rlt_pkg::COUNT_W-1:0];
					default: begin
					end
				endcase
			end
			if (state_q == rlt_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (req_acc) walk_q <= '0;
			else if (issue) walk_q <= walk_q + 1'b1;
			pend_s1 <= issue;
			if (state_q != rlt_pkg::ST_DIV) dcnt_q <= '0;
			else dcnt_q <= dcnt_q + 1'b1;
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	// item capture, stats accumulation, divider, result register
	always_ff @(posedge clk) begin
		if (req_acc) begin
			kind_q   <= rlt_pkg::kind_t'(kind);
			hit_q    <= hit_in;
			slot_q   <= offset[IDX_W-1:0];
			delay_q  <= measured_delay;
			skip_q   <= skip_code;
			err_q    <= error_number;
			nvalid_q <= '0;
			nskip_q  <= '0;
			lo_q     <= NO_RESP;
			hi_q     <= NO_RESP;
			quo_q    <= '0;
		end else if (pend_s1) begin
			if (rd_v) begin
				if (nvalid_q == '0 || rd_t < lo_q) lo_q <= rd_t;
				if (nvalid_q == '0 || rd_t > hi_q) hi_q <= rd_t;
				quo_q    <= quo_q + SUM_W'(rd_t);
				nvalid_q <= nvalid_q + 1'b1;
			end else if (rd_skip != '0) begin
				nskip_q <= nskip_q + 1'b1;
			end
		end else if (state_q == rlt_pkg::ST_DIV) begin
			quo_q <= {quo_q[SUM_W-2:0], trial_ge};
			rem_q <= trial_ge ? CNT_W'(trial - {1'b0, nvalid_q}) : trial[CNT_W-1:0];
		end
		if (state_q == rlt_pkg::ST_WALK) rem_q <= '0;

		if (rsp_load) begin
			in_range      <= 1'b0;
			entry_valid   <= 1'b0;
			entry_time    <= '0;
			entry_skip    <= '0;
			entry_error   <= '0;
			valid_count   <= '0;
			skipped_count <= '0;
			min_time      <= '0;
			max_time      <= '0;
			mean_time     <= '0;
			if (state_q == rlt_pkg::ST_FIN) begin
				in_range      <= 1'b1;
				valid_count   <= rlt_pkg::COUNT_W'(nvalid_q);
				skipped_count <= rlt_pkg::COUNT_W'(nskip_q);
				min_time      <= rlt_pkg::OTIME_W'(lo_q);
				max_time      <= rlt_pkg::OTIME_W'(hi_q);
				mean_time     <= (nvalid_q == '0) ? rlt_pkg::OTIME_W'(NO_RESP) :
					rlt_pkg::OTIME_W'(quo_q);
			end else begin
				in_range <= hit_q;
				if (kind_q == rlt_pkg::KIND_READ && hit_q) begin
					entry_valid <= rd_v;
					entry_time  <= rlt_pkg::OTIME_W'(rd_t);
					entry_skip  <= rd_skip;
					entry_error <= rd_err;
				end
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

### verif/reply_latency_table_unit_tb.sv
// Testbench for the reply latency table unit: directed and random beats checked against a table model.
`timescale 1ns / 1ps

module reply_latency_table_unit_tb;

	localparam int DEPTH     = rlt_pkg::TABLE_DEPTH_DEF;
	localparam int OTIME_W   = rlt_pkg::OTIME_W;
	localparam int SKIP_W    = rlt_pkg::SKIP_W;
	localparam int ERR_W     = rlt_pkg::ERR_W;
	localparam int COUNT_W   = rlt_pkg::COUNT_W;
	localparam int ADDR_W    = rlt_pkg::ADDR_W;
	localparam int DELAY_W   = rlt_pkg::DELAY_W;
	localparam int CFG_IDX_W = rlt_pkg::CFG_IDX_W;
	localparam logic [OTIME_W-1:0] NO_RESP = '1;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES = 500;

	typedef struct packed {
		logic               in_range;
		logic               entry_valid;
		logic [OTIME_W-1:0] entry_time;
		logic [SKIP_W-1:0]  entry_skip;
		logic [ERR_W-1:0]   entry_error;
		logic [COUNT_W-1:0] valid_count;
		logic [COUNT_W-1:0] skipped_count;
		logic [OTIME_W-1:0] min_time;
		logic [OTIME_W-1:0] max_time;
		logic [OTIME_W-1:0] mean_time;
	} table_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [ADDR_W-1:0]        cfg_data = '0;
	logic                     req_valid = 1'b0;
	logic                     req_ready;
	logic [1:0]               kind = '0;
	logic [ADDR_W-1:0]        address = '0;
	logic [DELAY_W-1:0]       measured_delay = '0;
	logic [SKIP_W-1:0]        skip_code = '0;
	logic signed [ERR_W-1:0]  error_number = '0;
	logic                     rsp_valid;
	logic                     rsp_ready = 1'b0;
	logic                     in_range;
	logic                     entry_valid;
	logic [OTIME_W-1:0]       entry_time;
	logic [SKIP_W-1:0]        entry_skip;
	logic signed [ERR_W-1:0]  entry_error;
	logic [COUNT_W-1:0]       valid_count;
	logic [COUNT_W-1:0]       skipped_count;
	logic [OTIME_W-1:0]       min_time;
	logic [OTIME_W-1:0]       max_time;
	logic [OTIME_W-1:0]       mean_time;

	// table model
	bit                 valid_tbl [DEPTH];
	logic [OTIME_W-1:0] latency_tbl [DEPTH];
	logic [SKIP_W-1:0]  skip_tbl [DEPTH];
	logic [ERR_W-1:0]   error_tbl [DEPTH];
	logic [ADDR_W-1:0]  base_reg;
	logic [COUNT_W-1:0] count_reg;

	table_result_t pending_results [$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;

	reply_latency_table_unit u_dut (.*);

	always #10 clk = ~clk;

	function automatic void reset_table_model();
		for (int i = 0; i < DEPTH; i++) begin
			valid_tbl[i] = 1'b0;
			latency_tbl[i] = NO_RESP;
			skip_tbl[i] = '0;
			error_tbl[i] = '0;
		end
		base_reg = '0;
		count_reg = rlt_pkg::ENTRY_COUNT_RST;
	endfunction

	function automatic int unsigned live_entries();
		return (int'(count_reg) > DEPTH) ? DEPTH : int'(count_reg);
	endfunction

	function automatic bit slot_of(input logic [31:0] addr, output int unsigned slot);
		logic [31:0] off;
		off = addr - base_reg;
		slot = off;
		return (addr >= base_reg) && (off < live_entries());
	endfunction

	function automatic table_result_t apply_table_item(input rlt_pkg::kind_t k,
			input logic [31:0] addr, input logic [31:0] delay, input logic [1:0] sk,
			input logic [12:0] en);
		table_result_t r;
		int unsigned slot;
		bit hit;
		int unsigned nvalid;
		int unsigned nskip;
		logic [63:0] sum;
		logic [OTIME_W-1:0] lo;
		logic [OTIME_W-1:0] hi;
		r = '0;
		hit = slot_of(addr, slot);
		r.in_range = hit;
		case (k)
		rlt_pkg::KIND_LOG: begin
			if (hit) begin
				valid_tbl[slot] = 1'b1;
				latency_tbl[slot] = (delay < NO_RESP) ? delay : NO_RESP;
			end
		end
		rlt_pkg::KIND_READ: begin
			if (hit) begin
				r.entry_valid = valid_tbl[slot];
				r.entry_time = latency_tbl[slot];
				r.entry_skip = skip_tbl[slot];
				r.entry_error = error_tbl[slot];
			end
		end
		rlt_pkg::KIND_SKIP: begin
			if (hit) begin
				valid_tbl[slot] = 1'b0;
				latency_tbl[slot] = NO_RESP;
				skip_tbl[slot] = sk;
				error_tbl[slot] = en;
			end
		end
		default: begin
			nvalid = 0;
			nskip = 0;
			sum = '0;
			lo = NO_RESP;
			hi = NO_RESP;
			for (int i = 0; i < live_entries(); i++) begin
				if (valid_tbl[i]) begin
					if (nvalid == 0 || latency_tbl[i] < lo)
						lo = latency_tbl[i];
					if (nvalid == 0 || latency_tbl[i] > hi)
						hi = latency_tbl[i];
					sum = sum + 64'(latency_tbl[i]);
					nvalid++;
				end else if (skip_tbl[i] != 0) begin
					nskip++;
				end
			end
			r.in_range = 1'b1;
			r.valid_count = COUNT_W'(nvalid);
			r.skipped_count = COUNT_W'(nskip);
			r.min_time = lo;
			r.max_time = hi;
			r.mean_time = (nvalid != 0) ? OTIME_W'(sum / 64'(nvalid)) : NO_RESP;
		end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns mismatch %s: got %0h expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// result checker
	always @(posedge clk) begin : check_blk
		table_result_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with nothing pending", 32'd0, 32'd0);
			end else begin
				want = pending_results.pop_front();
				check_field("in_range", 32'(in_range), 32'(want.in_range));
				check_field("entry_valid", 32'(entry_valid), 32'(want.entry_valid));
				check_field("entry_time", 32'(entry_time), 32'(want.entry_time));
				check_field("entry_skip", 32'(entry_skip), 32'(want.entry_skip));
				check_field("entry_error", 32'(entry_error[ERR_W-1:0]),
					32'(want.entry_error));
				check_field("valid_count", 32'(valid_count), 32'(want.valid_count));
				check_field("skipped_count", 32'(skipped_count), 32'(want.skipped_count));
				check_field("min_time", 32'(min_time), 32'(want.min_time));
				check_field("max_time", 32'(max_time), 32'(want.max_time));
				check_field("mean_time", 32'(mean_time), 32'(want.mean_time));
			end
		end
	end

	// receiver: random stalls, plus a long hold whenever hold_seq moves
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t ns timeout: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	task automatic send_item(input rlt_pkg::kind_t k, input logic [31:0] addr,
			input logic [31:0] delay, input logic [1:0] sk, input logic [12:0] en);
		table_result_t r;
		req_valid <= 1'b1;
		kind <= k;
		address <= addr;
		measured_delay <= delay;
		skip_code <= sk;
		error_number <= en;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		r = apply_table_item(k, addr, delay, sk, en);
		pending_results.insert(pending_results.size(), r);
	endtask

	task automatic write_reg(input rlt_pkg::reg_idx_t idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
		rlt_pkg::REG_BASE: base_reg = data;
		default: count_reg = data[COUNT_W-1:0];
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_address();
		int unsigned r;
		int unsigned n;
		n = live_entries();
		r = $urandom_range(99);
		if (r < 80 && n != 0)
			return base_reg + $urandom_range(n - 1);
		if (r < 90) begin
			case ($urandom_range(3))
			0: return base_reg - 32'd1;
			1: return base_reg + n;
			2: return base_reg + n - 32'd1;
			default: return base_reg;
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_delay();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50)
			return $urandom_range(5000);
		if (r < 80)
			return $urandom;
		if (r < 90)
			return '0;
		return '1;
	endfunction

	task automatic send_random_item();
		int unsigned r;
		logic [1:0] rk;
		logic [1:0] sk;
		logic [12:0] en;
		r = $urandom_range(99);
		rk = 2'($urandom);
		sk = 2'($urandom);
		en = ($urandom_range(9) == 0) ? 13'h1FFF : 13'($urandom);
		if (r < 5)
			send_item(rlt_pkg::kind_t'(rk), $urandom, $urandom, sk, en);
		else if (r < 45)
			send_item(rlt_pkg::KIND_LOG, pick_address(), pick_delay(), sk, en);
		else if (r < 72)
			send_item(rlt_pkg::KIND_READ, pick_address(), $urandom, sk, en);
		else if (r < 96)
			send_item(rlt_pkg::KIND_SKIP, pick_address(), $urandom, sk, en);
		else
			send_item(rlt_pkg::KIND_STATS, $urandom, $urandom, sk, en);
	endtask

	task automatic test_directed();
		// empty table, then the corners of the default window
		send_item(rlt_pkg::KIND_STATS, 32'h0, 32'h0, 2'd0, 13'h0);
		send_item(rlt_pkg::KIND_READ, 32'h0, 32'h0, 2'd0, 13'h0);
		send_item(rlt_pkg::KIND_LOG, 32'h0, 32'h0, 2'd0, 13'h0);
		send_item(rlt_pkg::KIND_LOG, 32'd255, 32'hFFFF_FFFF, 2'd0, 13'h0);
		send_item(rlt_pkg::KIND_LOG, 32'd256, 32'd7, 2'd0, 13'h0);
		send_item(rlt_pkg::KIND_READ, 32'h0, 32'h0, 2'd0, 13'h0);
		send_item(rlt_pkg::KIND_READ, 32'd255, 32'h0, 2'd0, 13'h0);
		send_item(rlt_pkg::KIND_READ, 32'd256, 32'h0, 2'd0, 13'h0);
		send_item(rlt_pkg::KIND_SKIP, 32'd5, 32'h0, 2'd3, 13'h1FFF);
		send_item(rlt_pkg::KIND_SKIP, 32'd6, 32'h0, 2'd1, 13'h1000);
		send_item(rlt_pkg::KIND_SKIP, 32'd7, 32'h0, 2'd2, 13'h0FFF);
		send_item(rlt_pkg::KIND_SKIP, 32'd300, 32'h0, 2'd2, 13'h0123);
		// a log on a skipped entry keeps its reason and error
		send_item(rlt_pkg::KIND_LOG, 32'd5, 32'd1000, 2'd0, 13'h0);
		send_item(rlt_pkg::KIND_READ, 32'd5, 32'h0, 2'd0, 13'h0);
		send_item(rlt_pkg::KIND_READ, 32'd6, 32'h0, 2'd0, 13'h0);
		send_item(rlt_pkg::KIND_STATS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 13'h1FFF);
		drain();
		// window at the top of the address space, count above the depth
		write_reg(rlt_pkg::REG_BASE, 32'hFFFF_FF00);
		write_reg(rlt_pkg::REG_COUNT, 32'd300);
		send_item(rlt_pkg::KIND_LOG, 32'hFFFF_FFFF, 32'd42, 2'd0, 13'h0);
		send_item(rlt_pkg::KIND_READ, 32'hFFFF_FFFF, 32'h0, 2'd0, 13'h0);
		send_item(rlt_pkg::KIND_READ, 32'hFFFF_FEFF, 32'h0, 2'd0, 13'h0);
		send_item(rlt_pkg::KIND_STATS, 32'h0, 32'h0, 2'd0, 13'h0);
		drain();
		// empty window
		write_reg(rlt_pkg::REG_COUNT, 32'd0);
		send_item(rlt_pkg::KIND_READ, 32'hFFFF_FF00, 32'h0, 2'd0, 13'h0);
		send_item(rlt_pkg::KIND_STATS, 32'h0, 32'h0, 2'd0, 13'h0);
		send_item(rlt_pkg::KIND_LOG, 32'hFFFF_FF00, 32'd9, 2'd0, 13'h0);
	endtask

	task automatic test_random_mix(input int idle_pct, input int stall, input logic [31:0] base,
			input logic [COUNT_W-1:0] count, input int items);
		logic [31:0] count_word;
		count_word = $urandom;
		count_word[COUNT_W-1:0] = count;
		drain();
		write_reg(rlt_pkg::REG_BASE, base);
		write_reg(rlt_pkg::REG_COUNT, count_word);
		stall_pct <= stall;
		send_idle_pct = idle_pct;
		for (int i = 0; i < items; i++) begin
			while ($urandom_range(99) < send_idle_pct) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
			send_random_item();
		end
	endtask

	task automatic test_input_backpressure();
		drain();
		write_reg(rlt_pkg::REG_BASE, 32'h0A00_0000);
		write_reg(rlt_pkg::REG_COUNT, 32'd64);
		stall_pct <= 0;
		hold_seq <= hold_seq + 1;
		for (int i = 0; i < 40; i++)
			send_random_item();
	endtask

	initial begin
		reset_table_model();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_mix(0, 0, 32'h0, 9'd256, 480);
		test_random_mix(60, 0, $urandom, 9'($urandom_range(1, 256)), 480);
		test_random_mix(0, 60, 32'hFFFF_FF80, 9'h1FF, 480);
		test_random_mix(10, 10, $urandom, 9'($urandom_range(1, 16)), 480);
		test_input_backpressure();
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
